// ===== src/i2da_pkg.sv =====
// ----------------------------------------------------------------------------
// i2da_pkg
// shared widths, character codes and control struct for the decimal formatter
// ----------------------------------------------------------------------------
package i2da_pkg;

	localparam int VALUE_W    = 64;
	localparam int NUM_DIGITS = 20;
	localparam int BCD_W      = 4 * NUM_DIGITS;
	localparam int CHAR_W     = 6;
	localparam int STEP_W     = $clog2(VALUE_W);
	localparam int REM_W      = $clog2(NUM_DIGITS + 1);

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(48);
	localparam logic [CHAR_W-1:0] CHAR_MINUS = CHAR_W'(45);

	typedef struct packed {
		logic load;
		logic step;
		logic shift;
	} i2da_ctrl_t;

endpackage

// ===== src/int_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// int_to_decimal_ascii
// 64-bit integer to decimal ascii text, one character per output item
// ----------------------------------------------------------------------------
// input channel s_*: tdata holds the value, tuser the command (0 unsigned,
// 1 signed two's complement). output channel m_*: tdata holds one ascii
// character, tlast marks the final character of a number.
// one number is handled at a time; s_tready is high only while idle.
// after acceptance the magnitude is converted by a bit-serial shift and
// add-three unit, then leading zero digits are dropped at one per cycle
// (up to 19), then the sign decides whether a minus sign goes out.
// characters then go out one per cycle while m_tready is high: the minus
// sign first for negative signed values, then the digits, most
// significant first.
// when the receiver stalls, the character and tlast hold until taken.
// reset returns the block to idle; a number in flight is dropped.
// ----------------------------------------------------------------------------
module int_to_decimal_ascii import i2da_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [VALUE_W-1:0] s_tdata,   // value[63:0]
	input  logic [0:0]         s_tuser,   // command[0]
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [7:0]         m_tdata,   // character[5:0], zero[7:6]
	output logic               m_tlast
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CONV = 3'd1;
	localparam logic [2:0] ST_SKIP = 3'd2;
	localparam logic [2:0] ST_SIGN = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [2:0]         state_q;
	logic [STEP_W-1:0]  cnt_q;
	logic [REM_W-1:0]   rem_q;
	logic               neg_q;
	logic               neg_in;
	logic [VALUE_W-1:0] magnitude;
	logic [3:0]         top_digit;
	logic [CHAR_W-1:0]  character;
	logic               accept;
	logic               take;
	i2da_ctrl_t         ctrl;

	assign accept    = s_tvalid && s_tready;
	assign take      = m_tvalid && m_tready;
	assign neg_in    = s_tuser[0] && s_tdata[VALUE_W-1];
	assign magnitude = neg_in ? (~s_tdata + VALUE_W'(1)) : s_tdata;

	always_comb begin
		ctrl.load  = accept;
		ctrl.step  = (state_q == ST_CONV);
		ctrl.shift = ((state_q == ST_SKIP) && (top_digit == 4'd0) && (rem_q > REM_W'(1)))
			|| ((state_q == ST_EMIT) && take && (rem_q != REM_W'(1)));
	end

	i2da_dabble u_dabble (
		.clk       (clk),
		.ctrl      (ctrl),
		.magnitude (magnitude),
		.top_digit (top_digit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			rem_q   <= '0;
			neg_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						neg_q   <= neg_in;
						cnt_q   <= '0;
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					cnt_q <= cnt_q + STEP_W'(1);
					if (cnt_q == STEP_W'(VALUE_W - 1)) begin
						rem_q   <= REM_W'(NUM_DIGITS);
						state_q <= ST_SKIP;
					end
				end
				ST_SKIP: begin
					if (ctrl.shift) begin
						rem_q <= rem_q - REM_W'(1);
					end else begin
						state_q <= neg_q ? ST_SIGN : ST_EMIT;
					end
				end
				ST_SIGN: begin
					if (take) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (take) begin
						if (rem_q == REM_W'(1)) begin
							state_q <= ST_IDLE;
						end else begin
							rem_q <= rem_q - REM_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign character = (state_q == ST_SIGN) ? CHAR_MINUS : (CHAR_ZERO + CHAR_W'(top_digit));
	assign s_tready  = (state_q == ST_IDLE);
	assign m_tvalid  = (state_q == ST_SIGN) || (state_q == ST_EMIT);
	assign m_tdata   = {2'b00, character};
	assign m_tlast   = (state_q == ST_EMIT) && (rem_q == REM_W'(1));

endmodule

// ===== src/i2da_dabble.sv =====
// ----------------------------------------------------------------------------
// i2da_dabble
// bit-serial binary to bcd converter (shift and add three), with digit shift-out
// ----------------------------------------------------------------------------
module i2da_dabble import i2da_pkg::*; (
	input  logic               clk,
	input  i2da_ctrl_t         ctrl,
	input  logic [VALUE_W-1:0] magnitude,
	output logic [3:0]         top_digit
);

	logic [VALUE_W-1:0] mag_q;
	logic [BCD_W-1:0]   bcd_q;
	logic [BCD_W-1:0]   adj;

	always_comb begin
		for (int d = 0; d < NUM_DIGITS; d++) begin
			if (bcd_q[4*d +: 4] > 4'd4) begin
				adj[4*d +: 4] = bcd_q[4*d +: 4] + 4'd3;
			end else begin
				adj[4*d +: 4] = bcd_q[4*d +: 4];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			mag_q <= magnitude;
			bcd_q <= '0;
		end else if (ctrl.step) begin
			bcd_q <= {adj[BCD_W-2:0], mag_q[VALUE_W-1]};
			mag_q <= {mag_q[VALUE_W-2:0], 1'b0};
		end else if (ctrl.shift) begin
			bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
		end
	end

	assign top_digit = bcd_q[BCD_W-1 -: 4];

endmodule

// ===== src/i2da_checker.sv =====
// ----------------------------------------------------------------------------
// i2da_checker
// port-level checks for the decimal formatter, bound to the top level
// ----------------------------------------------------------------------------
module i2da_checker import i2da_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               s_tvalid,
	input logic               s_tready,
	input logic [VALUE_W-1:0] s_tdata,
	input logic [0:0]         s_tuser,
	input logic               m_tvalid,
	input logic               m_tready,
	input logic [7:0]         m_tdata,
	input logic               m_tlast
);

	// output holds while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output changed while stalled");

	// never ready for a new number while characters are pending
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid)
		else $error("input ready while output valid");

	// conversion takes time after acceptance
	a_conv_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !m_tvalid && !s_tready)
		else $error("no conversion gap after accept");

	// the final character frees the input side
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid)
		else $error("not idle after final character");

	// a minus sign is never the final character
	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[5:0] == CHAR_MINUS) |-> !m_tlast)
		else $error("minus sign flagged last");

endmodule

bind int_to_decimal_ascii i2da_checker u_i2da_checker (.*);
